// ----- hdl/pcspt_pkg.sv -----
package pcspt_pkg;

    // Width of the pc and address fields on the channels
    localparam int FIELD_W = 48;

    // Confidence codes
    localparam logic [1:0] CONF_INIT      = 2'd0;
    localparam logic [1:0] CONF_TRANSIENT = 2'd1;
    localparam logic [1:0] CONF_STEADY    = 2'd2;
    localparam logic [1:0] CONF_NO_PRED   = 2'd3;

    // Registered result of a tag lookup
    typedef struct packed {
        logic       hit;    // pc matched a valid entry
        logic       free;   // some entry is in init state
        logic [1:0] conf;   // confidence of the matching entry
    } t_lk_flags;

    // Tag/confidence write from the update step
    typedef struct packed {
        logic       wr;     // write confidence at the index
        logic       alloc;  // also set valid and tag
        logic [1:0] conf;   // new confidence
    } t_cam_upd;

endpackage

// ----- hdl/pcspt_if.sv -----
interface pcspt_access_if;
    import pcspt_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] access_pc;
    logic [FIELD_W-1:0] access_address;

    modport source (output valid, access_pc, access_address, input ready);
    modport sink   (input valid, access_pc, access_address, output ready);
endinterface

interface pcspt_result_if;
    import pcspt_pkg::*;
    logic               valid;
    logic               ready;
    logic               table_hit;
    logic               entry_allocated;
    logic               prefetch_valid;
    logic [FIELD_W-1:0] prefetch_address;
    logic               useful_prefetch;

    modport source (output valid, table_hit, entry_allocated, prefetch_valid,
                    prefetch_address, useful_prefetch, input ready);
    modport sink   (input valid, table_hit, entry_allocated, prefetch_valid,
                    prefetch_address, useful_prefetch, output ready);
endinterface

// ----- hdl/pcspt_ram.sv -----
module pcspt_ram #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/pcspt_cam.sv -----
module pcspt_cam #(
    parameter int ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_look,
    input  logic [pcspt_pkg::FIELD_W-1:0] i_pc,
    input  pcspt_pkg::t_cam_upd        i_upd,
    input  logic [$clog2(ENTRIES)-1:0] i_upd_idx,
    input  logic [pcspt_pkg::FIELD_W-1:0] i_upd_tag,
    output pcspt_pkg::t_lk_flags       o_flags,
    output logic [$clog2(ENTRIES)-1:0] o_idx
);
    import pcspt_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic               r_valid [ENTRIES];
    logic [1:0]         r_conf  [ENTRIES];
    logic [FIELD_W-1:0] r_tag   [ENTRIES];

    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_init;
    logic [ENTRIES-1:0] w_init_low;
    logic [IDX_W-1:0]   w_hit_idx;
    logic [IDX_W-1:0]   w_free_idx;
    logic [1:0]         w_hit_conf;

    t_lk_flags          r_flags;
    logic [IDX_W-1:0]   r_idx;

    // parallel tag compare and init-state scan
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_tag[i] == i_pc);
            w_init[i]  = (r_conf[i] == CONF_INIT);
        end
    end

    // lowest init entry wins the allocation
    assign w_init_low = w_init & (~w_init + {{(ENTRIES-1){1'b0}}, 1'b1});

    // one-hot to index; a pc sits in at most one valid entry
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        w_hit_conf = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_idx  = w_hit_idx | IDX_W'(i);
                w_hit_conf = w_hit_conf | r_conf[i];
            end
            if (w_init_low[i]) begin
                w_free_idx = w_free_idx | IDX_W'(i);
            end
        end
    end

    // lookup result register
    always_ff @(posedge i_clk) begin
        if (i_look) begin
            r_flags.hit  <= |w_match;
            r_flags.free <= |w_init;
            r_flags.conf <= w_hit_conf;
            r_idx        <= (|w_match) ? w_hit_idx : w_free_idx;
        end
    end

    // valid and confidence: cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_conf[i]  <= CONF_INIT;
            end
        end else if (i_upd.wr) begin
            r_conf[i_upd_idx] <= i_upd.conf;
            if (i_upd.alloc) begin
                r_valid[i_upd_idx] <= 1'b1;
            end
        end
    end

    // tags are only read behind a valid bit
    always_ff @(posedge i_clk) begin
        if (i_upd.wr && i_upd.alloc) begin
            r_tag[i_upd_idx] <= i_upd_tag;
        end
    end

    assign o_flags = r_flags;
    assign o_idx   = r_idx;
endmodule

// ----- hdl/pc_stride_prefetch_table_unit.sv -----
// Channel   | Dir | Modport              | Payload
// i_access  | in  | pcspt_access_if.sink | access_pc, access_address
// o_result  | out | pcspt_result_if.source | table_hit, entry_allocated,
//           |     |                      | prefetch_valid, prefetch_address, useful_prefetch
//
// Each item passes a tag lookup, an entry RAM read, then a read-modify-write.
// The next item is taken in the write-back cycle; the registered lookup and the
// registered entry RAM read set that loop.
// Reset clears the valid bits and confidence at once; no clearing pass.
// A result waiting in the output register stalls the write-back of the next item.
module pc_stride_prefetch_table_unit #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ADDRESS_BITS  = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcspt_access_if.sink          i_access,
    pcspt_result_if.source        o_result
);
    import pcspt_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int AB     = ADDRESS_BITS;
    localparam int WORD_W = 2 * AB + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [FIELD_W-1:0] r_pc;
    logic [AB-1:0]      r_addr;

    logic               w_accept;
    logic               w_out_free;
    logic               w_done;

    t_lk_flags          w_flags;
    logic [IDX_W-1:0]   w_idx;
    t_cam_upd           w_cam_upd;

    logic [WORD_W-1:0]  w_rdata;
    logic [WORD_W-1:0]  w_wdata;
    logic               w_we;

    logic [AB-1:0]      w_last;
    logic [AB-1:0]      w_stride;
    logic               w_used;
    logic [AB-1:0]      w_delta;
    logic               w_eq;
    logic [1:0]         w_conf_new;
    logic [AB-1:0]      w_stride_new;
    logic               w_used_new;
    logic [AB-1:0]      w_sum_stride;
    logic [AB-1:0]      w_sum_delta;
    logic               w_pf_valid;
    logic [AB-1:0]      w_pf_addr;
    logic               w_useful;
    logic               w_alloc;

    logic               r_out_valid;
    logic               r_hit;
    logic               r_alloc;
    logic               r_pf_valid;
    logic [FIELD_W-1:0] r_pf_addr;
    logic               r_useful;

    // handshake
    assign w_out_free      = !r_out_valid || o_result.ready;
    assign w_done          = (r_state == ST_UPD) && w_out_free;
    assign i_access.ready  = (r_state == ST_IDLE) || w_done;
    assign w_accept        = i_access.valid && i_access.ready;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_LOOK;
            ST_LOOK: n_state = ST_READ;
            ST_READ: n_state = ST_UPD;
            ST_UPD: begin
                if (w_done) n_state = w_accept ? ST_LOOK : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // input item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pc   <= i_access.access_pc;
            r_addr <= AB'(i_access.access_address);
        end
    end

    // tag store and lookup
    pcspt_cam #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_cam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_look    (r_state == ST_LOOK),
        .i_pc      (r_pc),
        .i_upd     (w_cam_upd),
        .i_upd_idx (w_idx),
        .i_upd_tag (r_pc),
        .o_flags   (w_flags),
        .o_idx     (w_idx)
    );

    // entry payload: {used, stride, last address}
    pcspt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_wdata),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    assign w_last   = w_rdata[AB-1:0];
    assign w_stride = w_rdata[2*AB-1:AB];
    assign w_used   = w_rdata[2*AB];

    // stride check and confidence update
    assign w_delta      = r_addr - w_last;
    assign w_eq         = (w_stride == w_delta);
    assign w_sum_stride = r_addr + w_stride;
    assign w_sum_delta  = r_addr + w_delta;

    always_comb begin
        w_stride_new = w_stride;
        if (w_eq) begin
            w_conf_new = (w_flags.conf == CONF_NO_PRED) ? CONF_TRANSIENT : CONF_STEADY;
        end else if (w_flags.conf == CONF_INIT) begin
            w_conf_new   = CONF_TRANSIENT;
            w_stride_new = w_delta;
        end else if (w_flags.conf == CONF_STEADY) begin
            w_conf_new = CONF_INIT;
        end else begin
            w_conf_new   = CONF_NO_PRED;
            w_stride_new = w_delta;
        end
    end

    assign w_pf_valid = w_flags.hit && (w_conf_new != CONF_NO_PRED);
    assign w_useful   = w_flags.hit && w_eq && !w_used;
    // used stays set only when no prefetch goes out
    assign w_used_new = (w_conf_new == CONF_NO_PRED) ? w_used : 1'b0;
    // new stride differs from the old one only on a wrong stride outside steady
    assign w_pf_addr  = (!w_eq && (w_flags.conf != CONF_STEADY)) ? w_sum_delta
                                                                 : w_sum_stride;
    assign w_alloc    = !w_flags.hit && w_flags.free;

    // write-back
    always_comb begin
        w_we      = w_done && (w_flags.hit || w_alloc);
        w_wdata   = w_flags.hit ? {w_used_new, w_stride_new, r_addr}
                                : {1'b0, {AB{1'b0}}, r_addr};
        w_cam_upd.wr    = w_we;
        w_cam_upd.alloc = w_alloc;
        w_cam_upd.conf  = w_flags.hit ? w_conf_new : CONF_TRANSIENT;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_hit      <= w_flags.hit;
            r_alloc    <= w_alloc;
            r_pf_valid <= w_pf_valid;
            r_pf_addr  <= w_pf_valid ? FIELD_W'(w_pf_addr) : '0;
            r_useful   <= w_useful;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.table_hit        = r_hit;
    assign o_result.entry_allocated  = r_alloc;
    assign o_result.prefetch_valid   = r_pf_valid;
    assign o_result.prefetch_address = r_pf_addr;
    assign o_result.useful_prefetch  = r_useful;
endmodule

// ----- hdl/pcspt_checker.sv -----
module pcspt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_hit,
    input logic        i_alloc,
    input logic        i_pf_valid,
    input logic [47:0] i_pf_addr,
    input logic        i_useful
);
    // input stays not ready while a taken item is in its lookup and RAM read
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready ##1 !i_in_ready)
        else $error("input taken during lookup or read");

    // an item never both hits and allocates
    a_hit_alloc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_hit && i_alloc))
        else $error("hit and allocation in one item");

    // prefetch only from a hit, a useful flag only with a prefetch
    a_pf_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_pf_valid || i_useful)) |-> (i_hit && i_pf_valid))
        else $error("prefetch or useful flag without a hit");

    // no prefetch means a zero address
    a_pf_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_pf_valid) |-> (i_pf_addr == 48'd0))
        else $error("prefetch address set without a prefetch");

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_hit) && $stable(i_alloc) &&
             $stable(i_pf_valid) && $stable(i_pf_addr) && $stable(i_useful)))
        else $error("stalled item changed");
endmodule

bind pc_stride_prefetch_table_unit pcspt_checker u_pcspt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_access.valid),
    .i_in_ready  (i_access.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_hit       (o_result.table_hit),
    .i_alloc     (o_result.entry_allocated),
    .i_pf_valid  (o_result.prefetch_valid),
    .i_pf_addr   (o_result.prefetch_address),
    .i_useful    (o_result.useful_prefetch)
);

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcspt_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDRESS_BITS  = 48;
    localparam int STREAMS       = 96;
    localparam int PHASE_ITEMS   = 225;
    localparam int HOLD_CYCLES   = 300;

    // One result item as seen on the output channel
    typedef struct packed {
        logic               hit;
        logic               alloc;
        logic               pf_valid;
        logic [FIELD_W-1:0] pf_addr;
        logic               useful;
    } t_prefetch_result;

    // Shadow copy of the prediction table plus the queue of results it predicts
    class prefetch_scoreboard;
        logic               tab_valid  [TABLE_ENTRIES];
        logic [FIELD_W-1:0] tab_tag    [TABLE_ENTRIES];
        logic [FIELD_W-1:0] tab_last   [TABLE_ENTRIES];
        logic [FIELD_W-1:0] tab_stride [TABLE_ENTRIES];
        logic [1:0]         tab_conf   [TABLE_ENTRIES];
        logic               tab_used   [TABLE_ENTRIES];
        t_prefetch_result   expected_prefetches[$];
        int                 mismatches;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tab_valid[i]  = 1'b0;
                tab_tag[i]    = '0;
                tab_last[i]   = '0;
                tab_stride[i] = '0;
                tab_conf[i]   = CONF_INIT;
                tab_used[i]   = 1'b0;
            end
            mismatches = 0;
        endfunction

        // Lookup and update for one accepted access; queues the expected result
        function void predict_access(logic [FIELD_W-1:0] pc, logic [FIELD_W-1:0] addr);
            int                 hit_idx;
            int                 free_idx;
            logic [FIELD_W-1:0] delta;
            logic [1:0]         conf;
            t_prefetch_result   r;
            hit_idx  = -1;
            free_idx = -1;
            r        = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (free_idx < 0 && tab_conf[i] == CONF_INIT)
                    free_idx = i;
                if (hit_idx < 0 && tab_valid[i] && tab_tag[i] == pc)
                    hit_idx = i;
            end
            if (hit_idx >= 0) begin
                delta = addr - tab_last[hit_idx];
                conf  = tab_conf[hit_idx];
                r.hit = 1'b1;
                if (tab_stride[hit_idx] == delta) begin
                    tab_conf[hit_idx] = (conf == CONF_NO_PRED) ? CONF_TRANSIENT : CONF_STEADY;
                    if (!tab_used[hit_idx]) begin
                        r.useful = 1'b1;
                        tab_used[hit_idx] = 1'b1;
                    end
                end else if (conf == CONF_INIT) begin
                    tab_stride[hit_idx] = delta;
                    tab_conf[hit_idx]   = CONF_TRANSIENT;
                end else if (conf == CONF_STEADY) begin
                    // steady entry misses once: back to init, stride kept
                    tab_conf[hit_idx] = CONF_INIT;
                end else begin
                    tab_stride[hit_idx] = delta;
                    tab_conf[hit_idx]   = CONF_NO_PRED;
                end
                if (tab_conf[hit_idx] != CONF_NO_PRED) begin
                    tab_used[hit_idx] = 1'b0;
                    r.pf_valid = 1'b1;
                    r.pf_addr  = addr + tab_stride[hit_idx];
                end
                tab_last[hit_idx] = addr;
            end else if (free_idx >= 0) begin
                // miss: take the first init entry, even a still-valid one
                r.alloc              = 1'b1;
                tab_valid[free_idx]  = 1'b1;
                tab_tag[free_idx]    = pc;
                tab_last[free_idx]   = addr;
                tab_stride[free_idx] = '0;
                tab_conf[free_idx]   = CONF_TRANSIENT;
                tab_used[free_idx]   = 1'b0;
            end
            // table full: nothing changes, all-zero result
            expected_prefetches.push_back(r);
        endfunction

        function void compare_field(string name, logic [FIELD_W-1:0] exp_v,
                                    logic [FIELD_W-1:0] got_v);
            if (exp_v !== got_v) begin
                $display("%0t: mismatch on %s: expected %0h, actual %0h",
                         $time, name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_result(t_prefetch_result got);
            t_prefetch_result exp_r;
            if (expected_prefetches.size() == 0) begin
                $display("%0t: result item with none expected: actual %0h", $time, got);
                mismatches++;
                return;
            end
            exp_r = expected_prefetches.pop_front();
            compare_field("table_hit",        exp_r.hit,      got.hit);
            compare_field("entry_allocated",  exp_r.alloc,    got.alloc);
            compare_field("prefetch_valid",   exp_r.pf_valid, got.pf_valid);
            compare_field("prefetch_address", exp_r.pf_addr,  got.pf_addr);
            compare_field("useful_prefetch",  exp_r.useful,   got.useful);
        endfunction

        function int outstanding();
            return expected_prefetches.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pcspt_access_if access_ch();
    pcspt_result_if result_ch();

    pc_stride_prefetch_table_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_access (access_ch.sink),
        .o_result (result_ch.source)
    );

    prefetch_scoreboard sb;

    int send_gap_pct;
    int rx_stall_pct;
    bit hold_req;
    int hold_left;

    // Access streams: pc, last address sent, current stride
    logic [FIELD_W-1:0] stream_pc     [STREAMS];
    logic [FIELD_W-1:0] stream_addr   [STREAMS];
    logic [FIELD_W-1:0] stream_stride [STREAMS];

    // Clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [FIELD_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [FIELD_W-1:0] rand_stride();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return FIELD_W'($urandom_range(1, 64) * 8);
            2:       return -FIELD_W'($urandom_range(1, 64) * 8);
            3:       return rand48();
            4:       return FIELD_W'(64);
            default: return -FIELD_W'(4096);
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            result_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin : watch_channels
        t_prefetch_result got;
        if (i_rst_n && access_ch.valid && access_ch.ready)
            sb.predict_access(access_ch.access_pc, access_ch.access_address);
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.hit      = result_ch.table_hit;
            got.alloc    = result_ch.entry_allocated;
            got.pf_valid = result_ch.prefetch_valid;
            got.pf_addr  = result_ch.prefetch_address;
            got.useful   = result_ch.useful_prefetch;
            sb.check_result(got);
        end
    end

    // Called just after a falling edge; returns just after a falling edge
    task automatic send_access(input logic [FIELD_W-1:0] pc, input logic [FIELD_W-1:0] addr);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            access_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        access_ch.valid          <= 1'b1;
        access_ch.access_pc      <= pc;
        access_ch.access_address <= addr;
        do @(posedge i_clk); while (!access_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        access_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic new_stream(input int k);
        stream_pc[k]     = rand48();
        stream_addr[k]   = rand48();
        stream_stride[k] = rand_stride();
    endtask

    // One random item: mostly a stream continuing its stride, some noise
    task automatic send_random(input int pool);
        int k;
        int roll;
        k    = $urandom_range(0, pool - 1);
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            // one-off pc
            send_access(rand48(), rand48());
            return;
        end
        if (roll < 5)
            new_stream(k);
        if (roll >= 5 && roll < 13) begin
            stream_addr[k] = rand48();
        end else begin
            if (roll >= 13 && roll < 18)
                stream_stride[k] = rand_stride();
            stream_addr[k] = stream_addr[k] + stream_stride[k];
        end
        send_access(stream_pc[k], stream_addr[k]);
    endtask

    localparam logic [FIELD_W-1:0] ONES = '1;

    initial begin : main
        int pools[4];
        int gaps[4];
        int stalls[4];
        sb = new();
        pools  = '{48, 72, 96, 60};
        gaps   = '{0, 49, 0, 22};
        stalls = '{0, 0, 49, 22};
        i_rst_n                  = 1'b0;
        access_ch.valid          = 1'b0;
        access_ch.access_pc      = '0;
        access_ch.access_address = '0;
        result_ch.ready          = 1'b0;
        send_gap_pct             = 0;
        rx_stall_pct             = 0;
        hold_req                 = 1'b0;
        hold_left                = 0;
        for (int i = 0; i < STREAMS; i++)
            new_stream(i);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pc 0 must not hit the cleared entries; walk it through every state
        send_access('0, '0);                       // allocate
        send_access('0, 48'h40);                   // wrong: -> no prediction
        send_access('0, 48'h80);                   // right: -> transient, useful
        send_access('0, 48'hC0);                   // right: -> steady
        send_access('0, 48'h100);                  // steady stays
        send_access('0, 48'h500);                  // wrong from steady: -> init
        send_access('0, 48'h7000);                 // init entry still hits
        // all-ones pc and address, stride across the wrap
        send_access(ONES, ONES);
        send_access(ONES, '0);
        send_access(ONES, 48'h1);
        send_access(ONES, 48'h2);
        send_access(ONES, 48'h1);                  // steady -> init, entry freed
        send_access(48'h1234_5678_9ABC, 48'h8000); // overwrites the freed entry
        send_access(ONES, 48'h3);                  // evicted pc misses again
        // negative stride wrapping below zero
        send_access(48'hC0DE_0000_0010, 48'h10);
        send_access(48'hC0DE_0000_0010, 48'h8);
        send_access(48'hC0DE_0000_0010, 48'h0);
        send_access(48'hC0DE_0000_0010, 48'hFFFF_FFFF_FFF8);
        // zero stride: same address again
        send_access(48'h8000_0000_0000, 48'h5555_AAAA_5555);
        send_access(48'h8000_0000_0000, 48'h5555_AAAA_5555);
        send_access(48'h8000_0000_0000, 48'h5555_AAAA_5555);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct = gaps[ph];
            rx_stall_pct = stalls[ph];
            // long receiver hold-off while the sender keeps pushing
            if (ph == 0)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random(pools[ph]);
            // sender pauses until the table has answered everything
            wait_drained();
        end

        repeat (30) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
